// File: hdl/assert_macros.svh
// Assertion macros shared by the handle allocator RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/hfla_pkg.sv
// Package for the handle free-list allocator: sizes, codes and the structs
// passed between the engine and the top level. No dependencies.
package hfla_pkg;

   localparam int HANDLE_CAPACITY = 1024;
   localparam int HANDLE_W        = 11;
   localparam int IDX_W           = $clog2(HANDLE_CAPACITY);
   localparam logic [HANDLE_W-1:0] CAPACITY_H = HANDLE_W'(HANDLE_CAPACITY);

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [IDX_W-1:0]    idx_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_DOUBLE    = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      handle_type handle;
   } req_type;

   typedef struct packed {
      handle_type new_handle;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      logic    data;
   } mark_wr_type;

   typedef struct packed {
      logic       en;
      idx_type    addr;
      handle_type data;
   } stack_wr_type;

endpackage

// File: hdl/handle_free_list_allocator.sv
// Handle free-list allocator: hands out nonzero handles and takes them back.
//
// Request channel (req_): one transaction per command. cmd 0 allocates a handle,
// cmd 1 releases the handle given. Response channel (rsp_): exactly one
// transaction per request, in order: the allocated handle (0 unless an allocate
// succeeds) and a status of ok, invalid handle, already released or exhausted.
// Released handles are reused last in, first out; with none free, fresh numbers
// are issued counting up from 1 until the capacity of 1024 is reached.
//
// After acceptance the request waits in the request register while the
// retired-mark RAM read completes, and its result is loaded into the response
// register when the request fires. One request is accepted every cycle while
// rsp_tready is high; the free stack and mark RAMs each take at most one read and
// one write per transaction; bypass registers cover writes from the preceding one.
// Reset clears the free count and fresh counter at once; the RAMs are not
// cleared. While the receiver holds rsp_tready low the response is held and at
// most one more request is taken into the request register before req_tready drops.
// Depends on hfla_pkg, hfla_engine and hfla_ram.
`include "assert_macros.svh"

module handle_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] cmd, [11:1] handle, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [10:0] new_handle, [12:11] status, [15:13] zero
);
   import hfla_pkg::*;

   logic         in_vld_ff;
   req_type      in_req_ff;
   logic         out_vld_ff;
   rsp_type      out_rsp_ff;
   logic         fire;
   logic         accept;
   req_type      req_in;
   idx_type      acc_idx;
   mark_wr_type  mark_wr;
   stack_wr_type stack_wr;
   idx_type      stack_raddr;
   logic         mark_rdata;
   handle_type   stack_rdata;
   rsp_type      rsp;

   assign req_in     = '{cmd: cmd_type'(req_tdata[0]), handle: req_tdata[HANDLE_W:1]};
   assign acc_idx    = IDX_W'(req_in.handle - HANDLE_W'(1));
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign accept     = req_tvalid && req_tready;

   hfla_ram #(
      .WIDTH (1),
      .DEPTH (HANDLE_CAPACITY)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr.en),
      .wr_addr (mark_wr.addr),
      .wr_data (mark_wr.data),
      .rd_en   (accept),
      .rd_addr (acc_idx),
      .rd_data (mark_rdata)
   );

   hfla_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (HANDLE_CAPACITY)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr.en),
      .wr_addr (stack_wr.addr),
      .wr_data (stack_wr.data),
      .rd_en   (fire),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   hfla_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .accept      (accept),
      .acc_idx     (acc_idx),
      .in_req      (in_req_ff),
      .mark_rdata  (mark_rdata),
      .stack_rdata (stack_rdata),
      .mark_wr     (mark_wr),
      .stack_wr    (stack_wr),
      .stack_raddr (stack_raddr),
      .rsp         (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_vld_ff <= 1'b1;
         end else if (fire) begin
            in_vld_ff <= 1'b0;
         end
         if (fire) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_in;
      end
      if (fire) begin
         out_rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_rsp_ff.status, out_rsp_ff.new_handle};

endmodule

// File: hdl/hfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hfla_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/hfla_engine.sv
// Allocate/release decision, free count and fresh counter, with forwarding
// around the registered reads of the stack and mark RAMs. Uses hfla_pkg.
`include "assert_macros.svh"

module hfla_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  accept,
   input  hfla_pkg::idx_type     acc_idx,
   input  hfla_pkg::req_type     in_req,
   input  logic                  mark_rdata,
   input  hfla_pkg::handle_type  stack_rdata,
   output hfla_pkg::mark_wr_type  mark_wr,
   output hfla_pkg::stack_wr_type stack_wr,
   output hfla_pkg::idx_type     stack_raddr,
   output hfla_pkg::rsp_type     rsp
);
   import hfla_pkg::*;

   handle_type cnt_ff, cnt_in;
   handle_type fresh_ff, fresh_in;
   logic       mark_hit_ff, mark_hit_in;
   logic       mark_fwd_ff, mark_fwd_in;
   logic       top_byp_ff;
   handle_type top_byp_val_ff;
   handle_type top_val;
   logic       mark_val;
   handle_type got;
   status_type status;

   always_comb begin
      cnt_in   = cnt_ff;
      fresh_in = fresh_ff;
      got      = '0;
      status   = ST_OK;
      mark_wr  = '0;
      stack_wr = '0;
      // Newest stack top and mark, past writes the RAM read could not see
      top_val  = top_byp_ff ? top_byp_val_ff : stack_rdata;
      mark_val = mark_hit_ff ? mark_fwd_ff : mark_rdata;
      if (fire) begin
         unique case (in_req.cmd)
            CMD_ALLOC: begin
               priority if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - HANDLE_W'(1);
                  got    = top_val;
               end else if (fresh_ff < CAPACITY_H) begin
                  fresh_in = fresh_ff + HANDLE_W'(1);
                  got      = fresh_ff + HANDLE_W'(1);
               end else begin
                  status = ST_EXHAUSTED;
               end
               if (status == ST_OK) begin
                  mark_wr = '{en: 1'b1, addr: IDX_W'(got - HANDLE_W'(1)), data: 1'b0};
               end
            end
            CMD_RELEASE: begin
               priority if (in_req.handle == '0 || in_req.handle > fresh_ff) begin
                  status = ST_INVALID;
               end else if (mark_val) begin
                  status = ST_DOUBLE;
               end else begin
                  mark_wr = '{en: 1'b1, addr: IDX_W'(in_req.handle - HANDLE_W'(1)),
                              data: 1'b1};
                  if (cnt_ff < CAPACITY_H) begin
                     stack_wr = '{en: 1'b1, addr: cnt_ff[IDX_W-1:0], data: in_req.handle};
                     cnt_in   = cnt_ff + HANDLE_W'(1);
                  end
               end
            end
            default: begin
               status = ST_INVALID;
            end
         endcase
      end
   end

   // Prefetch the new top entry for the next pop
   assign stack_raddr = IDX_W'(cnt_in - HANDLE_W'(1));
   assign rsp         = '{new_handle: got, status: status};

   // Catch a mark write landing on the same edge as the read for the next transaction
   always_comb begin
      mark_hit_in = mark_hit_ff;
      mark_fwd_in = mark_fwd_ff;
      if (accept) begin
         mark_hit_in = mark_wr.en && (mark_wr.addr == acc_idx);
         mark_fwd_in = mark_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         fresh_ff    <= '0;
         mark_hit_ff <= 1'b0;
         top_byp_ff  <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         fresh_ff    <= fresh_in;
         mark_hit_ff <= mark_hit_in;
         if (fire) begin
            top_byp_ff <= stack_wr.en;
         end
      end
   end

   always_ff @(posedge clock) begin
      mark_fwd_ff <= mark_fwd_in;
      if (fire) begin
         top_byp_val_ff <= stack_wr.data;
      end
   end

   `ASSERT_ALWAYS(a_count_le_fresh, cnt_ff <= fresh_ff, "free count above issued handles")
   `ASSERT_ALWAYS(a_fresh_le_cap, fresh_ff <= CAPACITY_H, "fresh counter beyond capacity")
   `ASSERT_ALWAYS(a_alloc_nonzero, mark_wr.en && !mark_wr.data |-> got != '0, "zero handle issued")
   `ASSERT_ALWAYS(a_exhaust, status == ST_EXHAUSTED |-> fresh_ff == CAPACITY_H, "exhausted early")
   `ASSERT_NEXT(a_push_top, fire && stack_wr.en, top_byp_ff && cnt_ff != '0, "push lost")

endmodule

// File: bench/handle_free_list_allocator_tb.sv
// Self-checking bench for handle_free_list_allocator: random and directed allocate and
// release transactions, with responses checked against a ledger of the free list.
// Depends on hfla_pkg and the allocator RTL.
module handle_free_list_allocator_tb;
   import hfla_pkg::*;

   localparam int STALL_PCT  = 13;
   localparam int WATCHDOG   = 2000;
   localparam int TAIL_WAIT  = 8;

   // Ledger of handle ownership: free stack, fresh counter and retired marks.
   class handle_ledger;
      handle_type stack_mem[HANDLE_CAPACITY];
      bit         retired[HANDLE_CAPACITY];
      handle_type free_count;
      handle_type next_fresh;
      rsp_type    awaited_responses[$];
      int         failures;
      int         exhausted_seen;

      function new();
         free_count     = '0;
         next_fresh     = '0;
         failures       = 0;
         exhausted_seen = 0;
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction

      function void log_request(cmd_type cmd, handle_type h);
         rsp_type want;
         want.new_handle = '0;
         want.status     = ST_OK;
         if (cmd == CMD_ALLOC) begin
            if (free_count != 0) begin
               free_count      = free_count - 1'b1;
               want.new_handle = stack_mem[free_count];
            end else if (next_fresh < CAPACITY_H) begin
               next_fresh      = next_fresh + 1'b1;
               want.new_handle = next_fresh;
            end else begin
               want.status = ST_EXHAUSTED;
               exhausted_seen++;
            end
            if (want.status == ST_OK)
               retired[want.new_handle - 1] = 1'b0;
         end else begin
            if (h == 0 || h > next_fresh) begin
               want.status = ST_INVALID;
            end else if (retired[h - 1]) begin
               want.status = ST_DOUBLE;
            end else begin
               retired[h - 1] = 1'b1;
               if (free_count < CAPACITY_H) begin
                  stack_mem[free_count] = h;
                  free_count            = free_count + 1'b1;
               end
            end
         end
         awaited_responses.push_back(want);
      endfunction

      function void check_response(logic [15:0] tdata);
         rsp_type got;
         rsp_type want;
         got.new_handle = tdata[10:0];
         got.status     = status_type'(tdata[12:11]);
         if (awaited_responses.size() == 0) begin
            failures++;
            $display("%0t: response transaction with none awaited, got new_handle %0d status %s",
                     $time, got.new_handle, got.status.name());
            return;
         end
         want = awaited_responses.pop_front();
         if (got.new_handle !== want.new_handle) begin
            failures++;
            $display("%0t: new_handle expected %0d, actual %0d",
                     $time, want.new_handle, got.new_handle);
         end
         if (got.status !== want.status) begin
            failures++;
            $display("%0t: status expected %s, actual %s",
                     $time, want.status.name(), got.status.name());
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [0] cmd, [11:1] handle, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [10:0] new_handle, [12:11] status, [15:13] zero

   handle_ledger ledger = new();
   bit           steady = 1'b0;
   int           quiet_cycles = 0;

   handle_free_list_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Receiver: stall at random outside the steady stretch, check each response transaction.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= STALL_PCT);
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_response(rsp_tdata);
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input cmd_type cmd, input handle_type h);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, h, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.log_request(cmd, h);
      if (!steady) begin
         while ($urandom_range(99) < STALL_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Hold off until every awaited response has arrived.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   // Mostly allocates or releases a handle in the issued range; the rest is noise.
   task automatic send_mixed(input int alloc_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < alloc_pct)
         send_request(CMD_ALLOC, handle_type'($urandom_range(2047)));
      else if (roll < 94 && ledger.next_fresh != 0)
         send_request(CMD_RELEASE, handle_type'($urandom_range(ledger.next_fresh, 1)));
      else
         send_request(CMD_RELEASE, handle_type'($urandom_range(2047)));
   endtask

   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: invalid handles on an empty pool, LIFO reuse, double release.
      send_request(CMD_RELEASE, 11'd0);
      send_request(CMD_RELEASE, 11'd1);
      send_request(CMD_RELEASE, 11'd2047);
      send_request(CMD_ALLOC,   11'd0);
      send_request(CMD_ALLOC,   11'd0);
      send_request(CMD_ALLOC,   11'd0);
      send_request(CMD_RELEASE, 11'd2);
      send_request(CMD_RELEASE, 11'd2);
      send_request(CMD_RELEASE, 11'd3);
      send_request(CMD_ALLOC,   11'd0);
      send_request(CMD_ALLOC,   11'd0);
      send_request(CMD_RELEASE, 11'd0);
      send_request(CMD_RELEASE, 11'd4);
      send_request(CMD_RELEASE, 11'd1024);
      send_request(CMD_ALLOC,   11'd0);
      send_request(CMD_RELEASE, 11'd1);
      send_request(CMD_RELEASE, 11'd1);
      send_request(CMD_ALLOC,   11'd2047);

      for (n = 0; n < 30; n++) send_mixed(50);
      drain_responses();

      // Fill the pool until allocation runs dry; the first part runs without stalls.
      steady = 1'b1;
      n = 0;
      while (ledger.exhausted_seen < 10 && n < 2000) begin
         if (n == 400) steady = 1'b0;
         send_mixed(96);
         n++;
      end
      steady = 1'b0;

      for (n = 0; n < 30; n++) send_mixed(20);
      for (n = 0; n < 30; n++) send_mixed(50);

      drain_responses();
      repeat (TAIL_WAIT) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// File: files.f
+incdir+hdl
hdl/hfla_pkg.sv
hdl/hfla_ram.sv
hdl/hfla_engine.sv
hdl/handle_free_list_allocator.sv
bench/handle_free_list_allocator_tb.sv
